// ----- hw/rtl/mkey_pkg.sv -----
// Shared constants and types for the Morton key block.
`timescale 1ns / 1ps
package mkey_pkg;

	// Bits per axis in the key
	localparam int AXIS_BITS = 21;
	// Largest axis value, 2^AXIS_BITS - 1
	localparam logic [AXIS_BITS-1:0] AXIS_FULL = {AXIS_BITS{1'b1}};

	localparam int COORD_W = 32;
	// Distance and range widths: both stay below 2^32 on the divide path
	localparam int DIFF_W  = 32;
	// Scaled distance d * (2^AXIS_BITS - 1)
	localparam int NUM_W   = DIFF_W + AXIS_BITS;
	localparam int INDEX_W = 24;
	localparam int KEY_W   = 63;
	localparam int IN_W    = 3 * COORD_W + INDEX_W;
	localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W       = KEY_W + INDEX_W;
	localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

	// Pipeline depth before the output register: range prep, scaling, divide steps
	localparam int PIPE_STAGES = AXIS_BITS + 2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

	// Box reset values, Q16.16
	localparam logic signed [COORD_W-1:0] BOX_MIN_RST = 32'sd0;
	localparam logic signed [COORD_W-1:0] BOX_MAX_RST = 32'sd65536;

	// How an axis value is formed
	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_FULL,
		SEL_DIV
	} axis_sel_t;

	// State of one axis between divide steps
	typedef struct packed {
		logic [DIFF_W-1:0]    rem;
		logic [AXIS_BITS-1:0] low;
		logic [DIFF_W-1:0]    rng;
		axis_sel_t            sel;
	} div_stage_t;

endpackage

// ----- hw/rtl/mkey_div_step.sv -----
// One registered restoring-division step of an axis lane.
`timescale 1ns / 1ps
module mkey_div_step (
	input  logic                clk,
	input  logic                en,
	input  mkey_pkg::div_stage_t cur,
	output mkey_pkg::div_stage_t nxt
);
	import mkey_pkg::*;

	logic [DIFF_W:0] trial;
	logic [DIFF_W:0] diff;
	logic            ge;
	div_stage_t      step;

	// Shift in the next numerator bit, subtract the range if it fits
	always_comb begin
		trial = {cur.rem, cur.low[AXIS_BITS-1]};
		diff  = trial - {1'b0, cur.rng};
		ge    = (trial >= {1'b0, cur.rng});
		step      = cur;
		step.rem  = ge ? diff[DIFF_W-1:0] : trial[DIFF_W-1:0];
		step.low  = (cur.low << 1) | AXIS_BITS'(ge);
	end

	// Advance the stage
	always_ff @(posedge clk) begin
		if (en) begin
			nxt <= step;
		end
	end

endmodule

// ----- hw/rtl/mkey_lane.sv -----
// One axis lane: range check, scaling and pipelined divide to an axis value.
`timescale 1ns / 1ps
module mkey_lane (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic signed [mkey_pkg::COORD_W-1:0]   coord,
	input  logic signed [mkey_pkg::COORD_W-1:0]   box_min,
	input  logic signed [mkey_pkg::COORD_W-1:0]   box_max,
	output logic        [mkey_pkg::AXIS_BITS-1:0] axis_val
);
	import mkey_pkg::*;

	logic signed [COORD_W:0] d_wide;
	logic signed [COORD_W:0] r_wide;
	axis_sel_t               sel_c;

	logic [DIFF_W-1:0] d_s1;
	logic [DIFF_W-1:0] r_s1;
	axis_sel_t         sel_s1;

	logic [NUM_W-1:0]  num;
	div_stage_t        init_c;
	div_stage_t        stg [AXIS_BITS+1];
	div_stage_t        last;

	// Classify the point against the box and take distance and range
	always_comb begin
		d_wide = (COORD_W+1)'(coord) - (COORD_W+1)'(box_min);
		r_wide = (COORD_W+1)'(box_max) - (COORD_W+1)'(box_min);
		if (box_max <= box_min || coord <= box_min) begin
			sel_c = SEL_ZERO;
		end else if (coord >= box_max) begin
			sel_c = SEL_FULL;
		end else begin
			sel_c = SEL_DIV;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= d_wide[DIFF_W-1:0];
			r_s1   <= r_wide[DIFF_W-1:0];
			sel_s1 <= sel_c;
		end
	end

	// Scale the distance by 2^AXIS_BITS - 1 and seed the divider
	always_comb begin
		num = (NUM_W'(d_s1) << AXIS_BITS) - NUM_W'(d_s1);
		init_c.rem = num[NUM_W-1:AXIS_BITS];
		init_c.low = num[AXIS_BITS-1:0];
		init_c.rng = r_s1;
		init_c.sel = sel_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg[0] <= init_c;
		end
	end

	// One quotient bit per stage
	for (genvar i = 0; i < AXIS_BITS; i++) begin : g_step
		mkey_div_step u_step (
			.clk (clk),
			.en  (en),
			.cur (stg[i]),
			.nxt (stg[i+1])
		);
	end

	// Pick the saturated or divided value
	always_comb begin
		last = stg[AXIS_BITS];
		case (last.sel)
			SEL_FULL: axis_val = AXIS_FULL;
			SEL_DIV:  axis_val = last.low;
			default:  axis_val = '0;
		endcase
	end

endmodule

// ----- hw/rtl/mkey_merge.sv -----
// Merge stage: interleave the three axis values into the registered key.
`timescale 1ns / 1ps
module mkey_merge (
	input  logic                              clk,
	input  logic                              en,
	input  logic [mkey_pkg::AXIS_BITS-1:0]    val_x,
	input  logic [mkey_pkg::AXIS_BITS-1:0]    val_y,
	input  logic [mkey_pkg::AXIS_BITS-1:0]    val_z,
	output logic [mkey_pkg::KEY_W-1:0]        key_q
);
	import mkey_pkg::*;

	logic [KEY_W-1:0] key_c;

	// Place x bit i at 3i, y at 3i+1, z at 3i+2
	always_comb begin
		key_c = '0;
		for (int i = 0; i < AXIS_BITS; i++) begin
			key_c[3*i]     = val_x[i];
			key_c[3*i + 1] = val_y[i];
			key_c[3*i + 2] = val_z[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			key_q <= key_c;
		end
	end

endmodule

// ----- hw/rtl/morton_key_from_box_point.sv -----
// Top level: Morton key from a point normalized against a bounding box.
//
//  Channel  | Direction | Transaction
//  s_*      | in        | one point: coord_x, coord_y, coord_z, point_index
//  m_*      | out       | one key: morton_key, key_index
//  cfg_*    | in        | write of one box register, no read-back
//
// One point per cycle sustained while m_tready does not stall. Each point passes
// range prep, scaling, one divide stage per axis bit in each of three lanes, then
// the output register. Reset clears the valid pipeline and skid buffer and presets
// the box registers. A stall on m_tready freezes the whole pipeline; s_tready is
// registered, and a skid register holds the transaction taken during a stall.
`timescale 1ns / 1ps
module morton_key_from_box_point (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// coord_x[31:0], coord_y[63:32], coord_z[95:64], point_index[119:96]
	input  logic [mkey_pkg::IN_BYTES_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// morton_key[62:0], key_index[86:63], zero pad[87]
	output logic [mkey_pkg::OUT_BYTES_W-1:0]    m_tdata,
	input  logic                                cfg_we,
	input  logic [mkey_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mkey_pkg::COORD_W-1:0]        cfg_wdata
);
	import mkey_pkg::*;

	logic signed [COORD_W-1:0] box_min_q [3];
	logic signed [COORD_W-1:0] box_max_q [3];

	logic                  skid_vld_q;
	logic [IN_W-1:0]       skid_data_q;
	logic                  in_vld;
	logic [IN_W-1:0]       in_data;
	logic                  en;

	logic                  vld_q [PIPE_STAGES];
	logic [INDEX_W-1:0]    idx_q [PIPE_STAGES];
	logic                  out_vld_q;
	logic [INDEX_W-1:0]    out_idx_q;
	logic [KEY_W-1:0]      key_q;
	logic [AXIS_BITS-1:0]  axis_val [3];

	// Box registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				box_min_q[a] <= BOX_MIN_RST;
				box_max_q[a] <= BOX_MAX_RST;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_X: box_min_q[0] <= cfg_wdata;
				REG_MIN_Y: box_min_q[1] <= cfg_wdata;
				REG_MIN_Z: box_min_q[2] <= cfg_wdata;
				REG_MAX_X: box_max_q[0] <= cfg_wdata;
				REG_MAX_Y: box_max_q[1] <= cfg_wdata;
				REG_MAX_Z: box_max_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Advance the pipeline unless the output is held
	assign en       = !out_vld_q || m_tready;
	assign s_tready = !skid_vld_q;
	assign in_vld   = skid_vld_q || s_tvalid;
	assign in_data  = skid_vld_q ? skid_data_q : s_tdata[IN_W-1:0];

	// Skid buffer: catch a transaction accepted while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && s_tvalid && s_tready) begin
			skid_data_q <= s_tdata[IN_W-1:0];
		end
	end

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < PIPE_STAGES; s++) begin
				vld_q[s] <= 1'b0;
			end
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_vld;
			for (int s = 1; s < PIPE_STAGES; s++) begin
				vld_q[s] <= vld_q[s-1];
			end
			out_vld_q <= vld_q[PIPE_STAGES-1];
		end
	end

	// Index delay line
	always_ff @(posedge clk) begin
		if (en) begin
			idx_q[0] <= in_data[IN_W-1 -: INDEX_W];
			for (int s = 1; s < PIPE_STAGES; s++) begin
				idx_q[s] <= idx_q[s-1];
			end
			out_idx_q <= idx_q[PIPE_STAGES-1];
		end
	end

	// Axis lanes
	for (genvar a = 0; a < 3; a++) begin : g_lane
		mkey_lane u_lane (
			.clk      (clk),
			.en       (en),
			.coord    (in_data[a*COORD_W +: COORD_W]),
			.box_min  (box_min_q[a]),
			.box_max  (box_max_q[a]),
			.axis_val (axis_val[a])
		);
	end

	mkey_merge u_merge (
		.clk   (clk),
		.en    (en),
		.val_x (axis_val[0]),
		.val_y (axis_val[1]),
		.val_z (axis_val[2]),
		.key_q (key_q)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_BYTES_W'({out_idx_q, key_q});

endmodule
